[rtl/assert_macros.svh]
// Assertion helpers for the RTL files; rgba_sprite_merge.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RSM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`define RSM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define RSM_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`define RSM_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

[rtl/rsm_pkg.sv]
package rsm_pkg;

    localparam int PosW = 5;
    localparam int ByteW = 8;
    localparam int WordW = 32;
    localparam int CfgIdxW = 3;

    localparam logic [PosW-1:0] RedPosReset = 5'd24;
    localparam logic [PosW-1:0] GreenPosReset = 5'd16;
    localparam logic [PosW-1:0] BluePosReset = 5'd8;
    localparam logic [PosW-1:0] AlphaPosReset = 5'd0;

    localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;
    localparam logic [ByteW-1:0] AlphaClear = 8'h00;

    // floor(x / 65025) for x below 2^24 is (x * 1032) >> 26, or one more.
    localparam logic [15:0] BlendDiv = 16'd65025;
    localparam logic [10:0] BlendRecip = 11'd1032;
    localparam int BlendShift = 26;

    // Register stages inside the blend datapath.
    localparam int BlendDepth = 4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RED_POS   = 3'd0,
        REG_GREEN_POS = 3'd1,
        REG_BLUE_POS  = 3'd2,
        REG_ALPHA_POS = 3'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_COPY  = 2'd1,
        MODE_BLEND = 2'd2
    } mode_t;

    typedef struct packed {
        logic [PosW-1:0] red;
        logic [PosW-1:0] green;
        logic [PosW-1:0] blue;
        logic [PosW-1:0] alpha;
    } pos_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } ctl_t;

    typedef struct packed {
        logic [ByteW-1:0] sr;
        logic [ByteW-1:0] sg;
        logic [ByteW-1:0] sb;
        logic [ByteW-1:0] sa;
        logic [ByteW-1:0] dr;
        logic [ByteW-1:0] dg;
        logic [ByteW-1:0] db;
        logic [ByteW-1:0] da;
    } pix_t;

    function automatic logic [ByteW-1:0] get_byte(input logic [WordW-1:0] word,
                                                  input logic [PosW-1:0] pos);
        logic [WordW-1:0] shifted;
        shifted = word >> pos;
        return shifted[ByteW-1:0];
    endfunction

    function automatic logic [WordW-1:0] put_byte(input logic [ByteW-1:0] value,
                                                  input logic [PosW-1:0] pos);
        logic [WordW-1:0] wide;
        wide = {{(WordW-ByteW){1'b0}}, value};
        return wide << pos;
    endfunction

endpackage

[rtl/rsm_unpack.sv]
module rsm_unpack
    import rsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [WordW-1:0] sprite_pixel,
    input  logic [WordW-1:0] dest_pixel,
    input  pos_t             pos,
    output ctl_t             ctl,
    output pix_t             pix
);

    ctl_t ctl_reg;
    ctl_t ctl_next;
    pix_t pix_reg;
    pix_t pix_next;

    always_comb
    begin
        pix_next.sr = get_byte(sprite_pixel, pos.red);
        pix_next.sg = get_byte(sprite_pixel, pos.green);
        pix_next.sb = get_byte(sprite_pixel, pos.blue);
        pix_next.sa = get_byte(sprite_pixel, pos.alpha);
        pix_next.dr = get_byte(dest_pixel, pos.red);
        pix_next.dg = get_byte(dest_pixel, pos.green);
        pix_next.db = get_byte(dest_pixel, pos.blue);
        pix_next.da = get_byte(dest_pixel, pos.alpha);

        ctl_next.valid = accept;
        if (pix_next.sa == AlphaOpaque ||
            (pix_next.da == AlphaClear && pix_next.sa != AlphaClear))
        begin
            ctl_next.mode = MODE_COPY;
        end
        else if (pix_next.sa != AlphaClear)
        begin
            ctl_next.mode = MODE_BLEND;
        end
        else
        begin
            ctl_next.mode = MODE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign ctl = ctl_reg;
    assign pix = pix_reg;

endmodule

[rtl/rsm_blend.sv]
module rsm_blend
    import rsm_pkg::*;
(
    input  logic             clk,
    input  logic [ByteW-1:0] d,
    input  logic [ByteW-1:0] s,
    input  logic [ByteW-1:0] a,
    input  logic [ByteW-1:0] da,
    output logic [ByteW-1:0] color
);

    logic [15:0]      prod_d_reg;
    logic [15:0]      prod_d_next;
    logic [15:0]      prod_s_reg;
    logic [15:0]      prod_s_next;
    logic [ByteW-1:0] da_reg;
    logic [23:0]      num_reg;
    logic [24:0]      num_next;
    logic [23:0]      num2_reg;
    logic [ByteW-1:0] quo_reg;
    logic [34:0]      quo_prod;
    logic [ByteW-1:0] color_reg;
    logic [ByteW-1:0] color_next;
    logic [23:0]      quo_back;
    logic [23:0]      rem;

    always_comb
    begin
        prod_d_next = d * (AlphaOpaque - a);
        prod_s_next = s * a;
    end

    // The sum is at most 255 * 65025, so it fits 24 bits.
    always_comb
    begin
        num_next = 25'(prod_d_reg * da_reg) + {1'b0, prod_s_reg, 8'd0}
                   - {9'd0, prod_s_reg};
    end

    always_comb
    begin
        quo_prod = num_reg * BlendRecip;
    end

    always_comb
    begin
        quo_back = 24'(quo_reg * BlendDiv);
        rem = num2_reg - quo_back;
        if (rem >= {8'd0, BlendDiv})
        begin
            color_next = quo_reg + 8'd1;
        end
        else
        begin
            color_next = quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_d_reg <= prod_d_next;
        prod_s_reg <= prod_s_next;
        da_reg <= da;
        num_reg <= num_next[23:0];
        num2_reg <= num_reg;
        quo_reg <= quo_prod[BlendShift+ByteW-1:BlendShift];
        color_reg <= color_next;
    end

    assign color = color_reg;

endmodule

[rtl/rsm_pack.sv]
module rsm_pack
    import rsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  pix_t             pix,
    input  logic [ByteW-1:0] red,
    input  logic [ByteW-1:0] green,
    input  logic [ByteW-1:0] blue,
    input  pos_t             pos,
    output logic             done,
    output logic [WordW-1:0] merged_pixel,
    output logic             write_enable
);

    logic             done_reg;
    logic             we_reg;
    logic             we_next;
    logic [WordW-1:0] merged_reg;
    logic [WordW-1:0] merged_next;
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] al;

    always_comb
    begin
        r = pix.sr;
        g = pix.sg;
        b = pix.sb;
        al = pix.sa;
        we_next = 1'b0;
        unique case (ctl.mode)
            MODE_COPY:
            begin
                we_next = 1'b1;
            end
            MODE_BLEND:
            begin
                we_next = 1'b1;
                r = red;
                g = green;
                b = blue;
                al = (pix.sa > pix.da) ? pix.sa : pix.da;
            end
            default:
            begin
                we_next = 1'b0;
            end
        endcase
        if (we_next)
        begin
            merged_next = put_byte(r, pos.red) | put_byte(g, pos.green) |
                          put_byte(b, pos.blue) | put_byte(al, pos.alpha);
        end
        else
        begin
            merged_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            we_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
            we_reg <= ctl.valid & we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        merged_reg <= merged_next;
    end

    assign done = done_reg;
    assign write_enable = we_reg;
    assign merged_pixel = merged_reg;

endmodule

[rtl/rgba_sprite_merge.sv]
// Sprite pixel merge over a packed 32-bit destination pixel.
// A request is taken at a rising edge where start is high and busy is low.
// busy never rises: the pipeline takes one request per cycle, every cycle.
// Each request gives exactly one result, shown for one cycle with done high:
// merged_pixel and write_enable. When done is high and write_enable is low, merged_pixel is zero.
// Each request passes through unpack, two multiply stages, a reciprocal
// multiply, a remainder correction, then packing into the output register.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the byte positions of red, green, blue and alpha; cfg_ready is always high.
// Write positions only while no request is in flight; indexes past the list
// are ignored. Reset restores positions 24, 16, 8 and 0 and drops every
// request in flight. The receiver cannot stall, so no back-pressure exists.
`include "assert_macros.svh"

module rgba_sprite_merge
    import rsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [WordW-1:0]   sprite_pixel,
    input  logic [WordW-1:0]   dest_pixel,
    output logic               done,
    output logic [WordW-1:0]   merged_pixel,
    output logic               write_enable,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [PosW-1:0]    cfg_data
);

    pos_t       pos_reg;
    pos_t       pos_next;
    ctl_t       ctl_s1;
    pix_t       pix_s1;
    ctl_t       ctl_reg [BlendDepth];
    pix_t       pix_reg [BlendDepth];
    ctl_t       ctl_last;
    logic       last_copy;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RED_POS:   pos_next.red = cfg_data;
                REG_GREEN_POS: pos_next.green = cfg_data;
                REG_BLUE_POS:  pos_next.blue = cfg_data;
                REG_ALPHA_POS: pos_next.alpha = cfg_data;
                default:       pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg.red <= RedPosReset;
            pos_reg.green <= GreenPosReset;
            pos_reg.blue <= BluePosReset;
            pos_reg.alpha <= AlphaPosReset;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    rsm_unpack u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !busy),
        .sprite_pixel (sprite_pixel),
        .dest_pixel   (dest_pixel),
        .pos          (pos_reg),
        .ctl          (ctl_s1),
        .pix          (pix_s1)
    );

    // Control and the sprite and destination bytes follow the blend datapath stage by stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BlendDepth; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_s1;
            for (int i = 1; i < BlendDepth; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg[0] <= pix_s1;
        for (int i = 1; i < BlendDepth; i++)
        begin
            pix_reg[i] <= pix_reg[i-1];
        end
    end

    assign ctl_last = ctl_reg[BlendDepth-1];
    assign last_copy = ctl_last.valid && (ctl_last.mode == MODE_COPY);

    rsm_blend u_blend_r (
        .clk   (clk),
        .d     (pix_s1.dr),
        .s     (pix_s1.sr),
        .a     (pix_s1.sa),
        .da    (pix_s1.da),
        .color (red)
    );

    rsm_blend u_blend_g (
        .clk   (clk),
        .d     (pix_s1.dg),
        .s     (pix_s1.sg),
        .a     (pix_s1.sa),
        .da    (pix_s1.da),
        .color (green)
    );

    rsm_blend u_blend_b (
        .clk   (clk),
        .d     (pix_s1.db),
        .s     (pix_s1.sb),
        .a     (pix_s1.sa),
        .da    (pix_s1.da),
        .color (blue)
    );

    rsm_pack u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_last),
        .pix          (pix_reg[BlendDepth-1]),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pos          (pos_reg),
        .done         (done),
        .merged_pixel (merged_pixel),
        .write_enable (write_enable)
    );

    `RSM_ASSERT_IMPLIES(a_nowrite_zero, clk, rst_n, done && !write_enable, merged_pixel == '0)
    `RSM_ASSERT_IMPLIES(a_write_has_done, clk, rst_n, write_enable, done)
    `RSM_ASSERT_NEXT(a_last_stage_done, clk, rst_n, ctl_last.valid, done)
    `RSM_ASSERT_NEXT(a_copy_writes, clk, rst_n, last_copy, write_enable)

endmodule

[tb/rgba_sprite_merge_checker.sv]
`timescale 1ns / 1ps

module rgba_sprite_merge_checker
    import rsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [WordW-1:0]   sprite_pixel,
    input  logic [WordW-1:0]   dest_pixel,
    input  logic               done,
    input  logic [WordW-1:0]   merged_pixel,
    input  logic               write_enable,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [PosW-1:0]    cfg_data,
    output int                 fail_count,
    output int                 open_count
);

    typedef struct packed {
        logic [WordW-1:0] pixel;
        logic             we;
    } merge_result_t;

    logic [PosW-1:0] red_at;
    logic [PosW-1:0] green_at;
    logic [PosW-1:0] blue_at;
    logic [PosW-1:0] alpha_at;

    merge_result_t merged_q[$];
    int            mismatches;
    int            in_flight;

    assign fail_count = mismatches;
    assign open_count = in_flight;

    function automatic int unsigned byte_at(input logic [WordW-1:0] word,
                                            input logic [PosW-1:0] pos);
        logic [WordW-1:0] shifted;
        shifted = word >> pos;
        return int'(shifted[ByteW-1:0]);
    endfunction

    function automatic logic [WordW-1:0] place_byte(input int unsigned value,
                                                    input logic [PosW-1:0] pos);
        logic [WordW-1:0] wide;
        wide = {{(WordW-ByteW){1'b0}}, value[ByteW-1:0]};
        return wide << pos;
    endfunction

    function automatic logic [WordW-1:0] pack_rgba(input int unsigned r, g, b, a);
        return place_byte(r, red_at) | place_byte(g, green_at) |
               place_byte(b, blue_at) | place_byte(a, alpha_at);
    endfunction

    function automatic int unsigned blend_channel(input int unsigned d, s, a, da);
        return (d * (255 - a) * da + s * a * 255) / 65025;
    endfunction

    function automatic merge_result_t merge_pixel(input logic [WordW-1:0] spr,
                                                  input logic [WordW-1:0] dst);
        int unsigned   sr, sg, sb, sa, da;
        merge_result_t res;
        sr = byte_at(spr, red_at);
        sg = byte_at(spr, green_at);
        sb = byte_at(spr, blue_at);
        sa = byte_at(spr, alpha_at);
        da = byte_at(dst, alpha_at);
        res = '0;
        if (sa == AlphaOpaque || (da == AlphaClear && sa != AlphaClear)) begin
            res.pixel = pack_rgba(sr, sg, sb, sa);
            res.we = 1'b1;
        end
        else if (sa != AlphaClear) begin
            res.pixel = pack_rgba(blend_channel(byte_at(dst, red_at), sr, sa, da),
                                  blend_channel(byte_at(dst, green_at), sg, sa, da),
                                  blend_channel(byte_at(dst, blue_at), sb, sa, da),
                                  (sa > da) ? sa : da);
            res.we = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        merge_result_t want;
        if (!rst_n)
        begin
            red_at <= RedPosReset;
            green_at <= GreenPosReset;
            blue_at <= BluePosReset;
            alpha_at <= AlphaPosReset;
            merged_q.delete();
            in_flight <= 0;
        end
        else
        begin
            if (done)
            begin
                if (merged_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: actual pixel %h write_enable %b",
                             $time, merged_pixel, write_enable);
                end
                else
                begin
                    want = merged_q.pop_front();
                    if (merged_pixel !== want.pixel)
                    begin
                        mismatches++;
                        $display("%0t: merged_pixel: expected %h actual %h",
                                 $time, want.pixel, merged_pixel);
                    end
                    if (write_enable !== want.we)
                    begin
                        mismatches++;
                        $display("%0t: write_enable: expected %b actual %b",
                                 $time, want.we, write_enable);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RED_POS: red_at <= cfg_data;
                    REG_GREEN_POS: green_at <= cfg_data;
                    REG_BLUE_POS: blue_at <= cfg_data;
                    REG_ALPHA_POS: alpha_at <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                merged_q.push_back(merge_pixel(sprite_pixel, dest_pixel));
            in_flight <= merged_q.size();
        end
    end

endmodule

[tb/rgba_sprite_merge_tb.sv]
`timescale 1ns / 1ps

module rgba_sprite_merge_tb;
    import rsm_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [WordW-1:0]   sprite_pixel;
    logic [WordW-1:0]   dest_pixel;
    logic               done;
    logic [WordW-1:0]   merged_pixel;
    logic               write_enable;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [PosW-1:0]    cfg_data;
    int                 fail_count;
    int                 open_count;

    logic [PosW-1:0]    alpha_pos_now;
    int                 sent;

    always #5 clk = ~clk;

    rgba_sprite_merge i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sprite_pixel (sprite_pixel),
        .dest_pixel   (dest_pixel),
        .done         (done),
        .merged_pixel (merged_pixel),
        .write_enable (write_enable),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgba_sprite_merge_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sprite_pixel (sprite_pixel),
        .dest_pixel   (dest_pixel),
        .done         (done),
        .merged_pixel (merged_pixel),
        .write_enable (write_enable),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .open_count   (open_count)
    );

    task automatic send_pixel(input logic [WordW-1:0] spr, input logic [WordW-1:0] dst);
        int gap;
        sprite_pixel <= spr;
        dest_pixel <= dst;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] value);
        int gap;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ALPHA_POS)
            alpha_pos_now = value;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_positions(input logic [PosW-1:0] r, g, b, a);
        write_reg(CfgIdxW'($urandom_range(4, 7)), PosW'($urandom()));
        write_reg(REG_RED_POS, r);
        write_reg(REG_GREEN_POS, g);
        write_reg(REG_BLUE_POS, b);
        write_reg(REG_ALPHA_POS, a);
        write_reg(CfgIdxW'($urandom_range(4, 7)), PosW'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ByteW-1:0] pick_alpha();
        case ($urandom_range(0, 7))
            0: return AlphaClear;
            1: return AlphaOpaque;
            2: return ByteW'($urandom_range(0, 255));
            default: return ByteW'($urandom_range(1, 254));
        endcase
    endfunction

    function automatic logic [WordW-1:0] build_pixel(input logic [ByteW-1:0] a);
        logic [WordW-1:0] word;
        logic [WordW-1:0] lane;
        word = $urandom();
        if ($urandom_range(0, 7) == 0)
            return word;
        lane = {{(WordW-ByteW){1'b0}}, {ByteW{1'b1}}} << alpha_pos_now;
        return (word & ~lane) | ({{(WordW-ByteW){1'b0}}, a} << alpha_pos_now);
    endfunction

    task automatic random_pixels(input int count);
        repeat (count)
            send_pixel(build_pixel(pick_alpha()), build_pixel(pick_alpha()));
    endtask

    initial
    begin
        int pos[4];
        int i;
        int j;
        int swap;
        rst_n <= 1'b0;
        start <= 1'b0;
        sprite_pixel <= '0;
        dest_pixel <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        alpha_pos_now = AlphaPosReset;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(32'h123456FF, 32'h89ABCDEF);
        send_pixel(32'hFFFFFFFF, 32'h00000000);
        send_pixel(32'h00000000, 32'hFFFFFFFF);
        send_pixel(32'hFFFFFF00, 32'h00000000);
        send_pixel(32'h80402001, 32'hFFFFFF00);
        send_pixel(32'hFFFFFF01, 32'hFFFFFFFF);
        send_pixel(32'h00000001, 32'hFFFFFFFF);
        send_pixel(32'hFFFFFFFE, 32'h000000FF);
        send_pixel(32'h000000FE, 32'hFFFFFF01);
        send_pixel(32'hC0A05080, 32'h30609040);
        send_pixel(32'h1020300A, 32'hF0E0D0C8);
        send_pixel(32'hFFFFFF80, 32'hFFFFFFFF);
        send_pixel(32'h000000FF, 32'hFFFFFFFF);
        wait_idle();

        set_positions(5'd0, 5'd0, 5'd0, 5'd0);
        random_pixels(40);
        wait_idle();
        set_positions(5'd31, 5'd31, 5'd31, 5'd31);
        random_pixels(40);
        wait_idle();
        set_positions(5'd0, 5'd8, 5'd16, 5'd24);
        random_pixels(40);
        wait_idle();
        set_positions(5'd2, 5'd12, 5'd22, 5'd25);
        random_pixels(40);
        wait_idle();

        while (sent < 740)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pos = '{0, 8, 16, 24};
                for (i = 0; i < 4; i++)
                begin
                    j = $urandom_range(0, 3);
                    swap = pos[i];
                    pos[i] = pos[j];
                    pos[j] = swap;
                end
            end
            else
            begin
                for (i = 0; i < 4; i++)
                    pos[i] = $urandom_range(0, 31);
            end
            set_positions(PosW'(pos[0]), PosW'(pos[1]), PosW'(pos[2]), PosW'(pos[3]));
            random_pixels($urandom_range(40, 90));
            wait_idle();
        end

        set_positions(RedPosReset, GreenPosReset, BluePosReset, AlphaPosReset);
        random_pixels(30);
        wait_idle();

        if (fail_count == 0)
            $display("rgba_sprite_merge_tb: clean");
        else
            $display("rgba_sprite_merge_tb: errors");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("rgba_sprite_merge_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rsm_pkg.sv
rtl/rsm_unpack.sv
rtl/rsm_blend.sv
rtl/rsm_pack.sv
rtl/rgba_sprite_merge.sv
tb/rgba_sprite_merge_checker.sv
tb/rgba_sprite_merge_tb.sv
